FILE: rtl/gasp_pkg.sv
// Package for the grid A* path search core: sizes, codes, state encoding
// and the packed word of the per-cell table. No dependencies.
package gasp_pkg;

	localparam int GRID_SIDE      = 32;
	localparam int SIDE_BITS      = 5;
	localparam int CELL_BITS      = 10;
	localparam int CELLS          = 1024;
	localparam int MAX_PATH       = 64;
	localparam int EMIT_BITS      = 6;
	localparam int COST_FRAC_BITS = 6;
	localparam int STEPS_BITS     = 11;
	localparam int COST_BITS      = 17;
	localparam int HEUR_BITS      = 12;
	localparam int CNT_BITS       = 11;
	localparam int COORD_BITS     = 22;
	localparam int CELLC_BITS     = 23;
	localparam int SIZE_BITS      = 6;
	localparam int TILE_BITS      = 16;
	localparam int REL_BITS       = 7;
	localparam int SQ_ITERS       = 12;
	localparam int SQ_BITS        = 24;
	localparam int DIV_STEP_BITS  = 5;

	typedef enum logic [1:0] {
		REG_GRID_W,
		REG_GRID_H,
		REG_TILE_X,
		REG_TILE_Y
	} reg_idx_t;

	typedef enum logic [2:0] {
		STS_PATH,
		STS_OUTSIDE,
		STS_SAME,
		STS_NOPATH,
		STS_TRUNC
	} status_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_CHECK,
		ST_CLEAR,
		ST_INIT,
		ST_SEL_A,
		ST_SEL_B,
		ST_SEL_C,
		ST_DEL_A,
		ST_DEL_B,
		ST_CUR_RD,
		ST_CUR_WR,
		ST_NB,
		ST_NB_CHK,
		ST_H_WAIT,
		ST_FIND_A,
		ST_FIND_B,
		ST_NB_WR,
		ST_NB_NEXT,
		ST_DST_WR,
		ST_EM_RD,
		ST_EM_CHK,
		ST_STATUS
	} state_t;

	typedef struct packed {
		logic                  closed;
		logic                  seen;
		logic [CELL_BITS-1:0]  parent;
		logic [STEPS_BITS-1:0] steps;
		logic [COST_BITS-1:0]  total;
	} cell_word_t;

endpackage

FILE: rtl/gasp_query_if.sv
// Query channel: start and destination world positions with valid/ready.
// Depends on gasp_pkg.
interface gasp_query_if import gasp_pkg::*; ();
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] start_world_x;
	logic signed [COORD_BITS-1:0] start_world_y;
	logic signed [COORD_BITS-1:0] end_world_x;
	logic signed [COORD_BITS-1:0] end_world_y;

	modport source(output valid, start_world_x, start_world_y, end_world_x, end_world_y,
		input ready);
	modport sink(input valid, start_world_x, start_world_y, end_world_x, end_world_y,
		output ready);
endinterface

FILE: rtl/gasp_path_if.sv
// Result channel: one path cell or status code per beat, with valid/ready.
// Depends on gasp_pkg.
interface gasp_path_if import gasp_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [SIDE_BITS-1:0] cell_x;
	logic [SIDE_BITS-1:0] cell_y;
	logic [2:0]           status;
	logic                 last;

	modport source(output valid, cell_x, cell_y, status, last, input ready);
	modport sink(input valid, cell_x, cell_y, status, last, output ready);
endinterface

FILE: rtl/gasp_div.sv
// Iterative restoring divider: signed world coordinate over tile step,
// truncating toward zero, one quotient bit per cycle. Depends on gasp_pkg.
module gasp_div import gasp_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic signed [COORD_BITS-1:0] dividend,
	input  logic [TILE_BITS-1:0]         divisor,
	output logic                         done,
	output logic signed [CELLC_BITS-1:0] quot
);

	logic                     busy_q;
	logic                     done_q;
	logic [DIV_STEP_BITS-1:0] step_q;
	logic [TILE_BITS-1:0]     rem_q;
	logic [COORD_BITS-1:0]    q_q;
	logic [TILE_BITS-1:0]     d_q;
	logic                     neg_q;
	logic [TILE_BITS:0]       trial;
	logic                     ge;

	// Shift in the next dividend bit and try the subtract
	assign trial = {rem_q, q_q[COORD_BITS-1]};
	assign ge    = trial >= {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				if (step_q == DIV_STEP_BITS'(COORD_BITS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				step_q <= step_q + 1'b1;
			end
		end
	end

	// Load magnitude and divisor, then one restoring step per cycle
	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			neg_q <= dividend[COORD_BITS-1];
			q_q   <= dividend[COORD_BITS-1] ? (COORD_BITS'(0) - dividend) : dividend;
			rem_q <= '0;
			d_q   <= (divisor == '0) ? TILE_BITS'(1) : divisor;
		end else if (busy_q) begin
			rem_q <= ge ? TILE_BITS'(trial - {1'b0, d_q}) : trial[TILE_BITS-1:0];
			q_q   <= {q_q[COORD_BITS-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = neg_q ? -$signed({1'b0, q_q}) : $signed({1'b0, q_q});

endmodule

FILE: rtl/gasp_hsqrt.sv
// Heuristic unit: squares the offsets on one small multiplier, then an
// iterative integer square root, rounded to nearest. Depends on gasp_pkg.
module gasp_hsqrt import gasp_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic signed [REL_BITS-1:0] dx,
	input  logic signed [REL_BITS-1:0] dy,
	output logic                       done,
	output logic [HEUR_BITS-1:0]       h
);

	logic                       busy_q;
	logic                       done_q;
	logic [3:0]                 step_q;
	logic signed [REL_BITS-1:0] dy_q;
	logic [10:0]                acc_q;
	logic [SQ_BITS-1:0]         rem_q;
	logic [SQ_BITS-1:0]         root_q;
	logic [SQ_BITS-1:0]         bit_q;
	logic [HEUR_BITS-1:0]       h_q;
	logic signed [REL_BITS-1:0] mul_op;
	logic signed [2*REL_BITS-1:0] prod;
	logic [10:0]                sq;
	logic [SQ_BITS-1:0]         trial;
	logic [10:0]                sum;

	// Shared squarer: x offset at start, y offset in the first busy cycle
	assign mul_op = busy_q ? dy_q : dx;
	assign prod   = mul_op * mul_op;
	assign sq     = prod[10:0];
	assign sum    = acc_q + sq;
	assign trial  = root_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				if (step_q == 4'(SQ_ITERS + 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				step_q <= step_q + 1'b1;
			end
		end
	end

	// Scale the squared distance, then one root digit per cycle
	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			acc_q <= sq;
			dy_q  <= dy;
		end else if (busy_q) begin
			if (step_q == '0) begin
				rem_q  <= SQ_BITS'({sum, (2 * COST_FRAC_BITS)'(0)});
				root_q <= '0;
				bit_q  <= SQ_BITS'(1) << (2 * SQ_ITERS - 2);
			end else if (step_q <= 4'(SQ_ITERS)) begin
				if (rem_q >= trial) begin
					rem_q  <= rem_q - trial;
					root_q <= (root_q >> 1) + bit_q;
				end else begin
					root_q <= root_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end else begin
				h_q <= HEUR_BITS'(root_q + SQ_BITS'(rem_q > root_q));
			end
		end
	end

	assign done = done_q;
	assign h    = h_q;

endmodule

FILE: rtl/grid_astar_path_search_core.sv
// Grid A* path search core: top level with sequencer, cell and open-list
// memories. Depends on gasp_pkg, gasp_query_if, gasp_path_if, gasp_div, gasp_hsqrt.
//
// A query beat on the query channel carries start and destination world
// positions; the core maps them to grid cells (four serial divisions), then
// runs 8-connected A* on the configured grid and returns beats on the path
// channel: the path from destination back to start, or a single status beat.
// A path too long for MAX_PATH beats ends in a truncation status beat. last
// marks the final beat of a query. A search first sweeps the 1024-entry
// cell table to zero, then per expansion scans the open list entry by entry
// and runs the heuristic unit for each neighbour that needs a heuristic.
// The open-list scan and the single memory read port set the run time.
// One query at a time: query.ready is high only when the core is idle. A
// result beat waits in an output register; while the receiver stalls the
// sequencer holds. The last beat of a query may still wait while the next
// query is accepted.
// Reset clears the sequencer and restores the registers to 32, 32, 100,
// 100. Registers are written over APB at byte address 4*index.
module grid_astar_path_search_core import gasp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	gasp_query_if.sink  query,
	gasp_path_if.source path,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	state_t state_q, state_d;

	// configuration registers
	logic [SIZE_BITS-1:0] gw_q, gh_q, w_eff, h_eff;
	logic [TILE_BITS-1:0] tsx_q, tsy_q;

	// query and cell coordinates
	logic signed [COORD_BITS-1:0] qin_q [4];
	logic signed [CELLC_BITS-1:0] crd_q [4];
	logic [1:0]                   div_idx_q;
	logic                         div_start, div_done;
	logic signed [CELLC_BITS-1:0] div_quot;
	logic signed [CELLC_BITS-1:0] wlim, hlim;
	logic                         dest_out, start_out, same_cell;
	logic [CELL_BITS-1:0]         start_idx, dest_idx;

	// search state
	status_t                stat_q;
	logic [CELL_BITS-1:0]   clr_q;
	logic [CNT_BITS-1:0]    open_cnt_q, scan_i_q, best_i_q, del_j_q;
	logic [COST_BITS-1:0]   best_cost_q;
	logic [CELL_BITS-1:0]   best_cell_q, scan_cell_q, cur_q, n_q, emit_c_q;
	logic                   del_ret_q;
	logic [STEPS_BITS-1:0]  cur_g_q, g_new;
	logic [1:0]             nb_ox_q, nb_oy_q;
	logic signed [REL_BITS-1:0] nx, ny, dx_q, dy_q;
	logic [CELL_BITS-1:0]   n_idx;
	logic                   nb_out, nb_dest;
	cell_word_t             nb_word_q;
	logic [COST_BITS-1:0]   f_q, f_new;
	logic                   h_start, h_done, better;
	logic [HEUR_BITS-1:0]   h_val;
	logic [EMIT_BITS-1:0]   emit_k_q;
	logic                   sel_take, sel_last, del_end, em_at_start, em_trunc;

	// memories
	cell_word_t           cm_mem [CELLS];
	cell_word_t           cm_q, cm_wdata;
	logic                 cm_we;
	logic [CELL_BITS-1:0] cm_waddr, cm_raddr;
	logic [CELL_BITS-1:0] ol_mem [CELLS];
	logic [CELL_BITS-1:0] ol_q, ol_wdata, ol_waddr, ol_raddr;
	logic                 ol_we;

	// output register
	logic                 ov_q, out_load, out_free, out_last, ol_last_q;
	logic [SIDE_BITS-1:0] out_x, out_y, ox_q, oy_q;
	status_t              out_sts, osts_q;

	// ---------------------------------------------------------------
	// Configuration port
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gw_q  <= SIZE_BITS'(32);
			gh_q  <= SIZE_BITS'(32);
			tsx_q <= TILE_BITS'(100);
			tsy_q <= TILE_BITS'(100);
		end else if (psel && penable && pwrite) begin
			unique case (reg_idx_t'(paddr[3:2]))
				REG_GRID_W: gw_q  <= pwdata[SIZE_BITS-1:0];
				REG_GRID_H: gh_q  <= pwdata[SIZE_BITS-1:0];
				REG_TILE_X: tsx_q <= pwdata[TILE_BITS-1:0];
				REG_TILE_Y: tsy_q <= pwdata[TILE_BITS-1:0];
				default:    ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx_t'(paddr[3:2]))
			REG_GRID_W: prdata = 32'(gw_q);
			REG_GRID_H: prdata = 32'(gh_q);
			REG_TILE_X: prdata = 32'(tsx_q);
			REG_TILE_Y: prdata = 32'(tsy_q);
			default:    prdata = '0;
		endcase
	end

	// Clamp grid size into 1..GRID_SIDE
	assign w_eff = (gw_q == '0) ? SIZE_BITS'(1) :
		(gw_q > SIZE_BITS'(GRID_SIDE)) ? SIZE_BITS'(GRID_SIDE) : gw_q;
	assign h_eff = (gh_q == '0) ? SIZE_BITS'(1) :
		(gh_q > SIZE_BITS'(GRID_SIDE)) ? SIZE_BITS'(GRID_SIDE) : gh_q;

	// ---------------------------------------------------------------
	// Shared units
	gasp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (qin_q[div_idx_q]),
		.divisor  (div_idx_q[0] ? tsy_q : tsx_q),
		.done     (div_done),
		.quot     (div_quot)
	);

	gasp_hsqrt u_hsqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (h_start),
		.dx     (dx_q),
		.dy     (dy_q),
		.done   (h_done),
		.h      (h_val)
	);

	// ---------------------------------------------------------------
	// Query checks
	assign wlim      = $signed({(CELLC_BITS - SIZE_BITS)'(0), w_eff});
	assign hlim      = $signed({(CELLC_BITS - SIZE_BITS)'(0), h_eff});
	assign dest_out  = crd_q[2][CELLC_BITS-1] || crd_q[3][CELLC_BITS-1] ||
		(crd_q[2] >= wlim) || (crd_q[3] >= hlim);
	assign start_out = crd_q[0][CELLC_BITS-1] || crd_q[1][CELLC_BITS-1] ||
		(crd_q[0] >= wlim) || (crd_q[1] >= hlim);
	assign same_cell = (crd_q[0] == crd_q[2]) && (crd_q[1] == crd_q[3]);
	assign start_idx = {crd_q[1][SIDE_BITS-1:0], crd_q[0][SIDE_BITS-1:0]};
	assign dest_idx  = {crd_q[3][SIDE_BITS-1:0], crd_q[2][SIDE_BITS-1:0]};

	// Open-list scan and removal
	assign sel_take = (scan_i_q == '0) || (cm_q.total < best_cost_q);
	assign sel_last = scan_i_q == (open_cnt_q - 1'b1);
	assign del_end  = del_j_q == (open_cnt_q - 1'b1);

	// Neighbour position and heuristic cost
	assign nx = REL_BITS'($signed({2'b00, cur_q[SIDE_BITS-1:0]}) +
		$signed({5'b00000, nb_ox_q}) - 7'sd1);
	assign ny = REL_BITS'($signed({2'b00, cur_q[CELL_BITS-1:SIDE_BITS]}) +
		$signed({5'b00000, nb_oy_q}) - 7'sd1);
	assign nb_out  = nx[REL_BITS-1] || ny[REL_BITS-1] ||
		(nx >= $signed({1'b0, w_eff})) || (ny >= $signed({1'b0, h_eff}));
	assign n_idx   = {ny[SIDE_BITS-1:0], nx[SIDE_BITS-1:0]};
	assign nb_dest = n_idx == dest_idx;
	assign g_new   = cur_g_q + 1'b1;
	assign f_new   = {g_new, COST_FRAC_BITS'(0)} + COST_BITS'(h_val);
	assign better  = !nb_word_q.seen || (nb_word_q.total > f_new);

	// Path walk
	assign em_at_start = cm_q.parent == emit_c_q;
	assign em_trunc    = !em_at_start && (emit_k_q == EMIT_BITS'(MAX_PATH - 1));
	assign out_free    = !ov_q || path.ready;

	// ---------------------------------------------------------------
	// Next state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:     if (query.valid) state_d = ST_DIV_GO;
			ST_DIV_GO:   state_d = ST_DIV_WAIT;
			ST_DIV_WAIT: if (div_done) state_d = (div_idx_q == 2'd3) ? ST_CHECK : ST_DIV_GO;
			ST_CHECK:    state_d = (dest_out || same_cell || start_out) ? ST_STATUS : ST_CLEAR;
			ST_CLEAR:    if (clr_q == '1) state_d = ST_INIT;
			ST_INIT:     state_d = ST_SEL_A;
			ST_SEL_A:    state_d = (open_cnt_q == '0) ? ST_STATUS : ST_SEL_B;
			ST_SEL_B:    state_d = ST_SEL_C;
			ST_SEL_C:    state_d = sel_last ? ST_DEL_A : ST_SEL_A;
			ST_DEL_A: begin
				if (!del_end) state_d = ST_DEL_B;
				else state_d = del_ret_q ? ST_NB_WR : ST_CUR_RD;
			end
			ST_DEL_B:    state_d = ST_DEL_A;
			ST_CUR_RD:   state_d = ST_CUR_WR;
			ST_CUR_WR:   state_d = ST_NB;
			ST_NB: begin
				if (nb_out) state_d = ST_NB_NEXT;
				else if (nb_dest) state_d = ST_DST_WR;
				else state_d = ST_NB_CHK;
			end
			ST_NB_CHK:   state_d = cm_q.closed ? ST_NB_NEXT : ST_H_WAIT;
			ST_H_WAIT: begin
				if (h_done) begin
					if (!better) state_d = ST_NB_NEXT;
					else state_d = nb_word_q.seen ? ST_FIND_A : ST_NB_WR;
				end
			end
			ST_FIND_A:   state_d = ST_FIND_B;
			ST_FIND_B:   state_d = (ol_q == n_q) ? ST_DEL_A : ST_FIND_A;
			ST_NB_WR:    state_d = ST_NB_NEXT;
			ST_NB_NEXT:  state_d = (nb_ox_q == 2'd2 && nb_oy_q == 2'd2) ? ST_SEL_A : ST_NB;
			ST_DST_WR:   state_d = ST_EM_RD;
			ST_EM_RD:    state_d = ST_EM_CHK;
			ST_EM_CHK: begin
				if (out_free) state_d = (em_trunc || em_at_start) ? ST_IDLE : ST_EM_RD;
			end
			ST_STATUS:   if (out_free) state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	// ---------------------------------------------------------------
	// Outputs of the sequencer: memory ports, unit starts, result load
	always_comb begin
		query.ready = 1'b0;
		div_start   = 1'b0;
		h_start     = 1'b0;
		cm_we       = 1'b0;
		cm_waddr    = cur_q;
		cm_wdata    = '0;
		cm_raddr    = emit_c_q;
		ol_we       = 1'b0;
		ol_waddr    = '0;
		ol_wdata    = n_q;
		ol_raddr    = scan_i_q[CELL_BITS-1:0];
		out_load    = 1'b0;
		out_x       = '0;
		out_y       = '0;
		out_sts     = stat_q;
		out_last    = 1'b1;
		unique case (state_q)
			ST_IDLE:   query.ready = 1'b1;
			ST_DIV_GO: div_start = 1'b1;
			ST_CLEAR: begin
				cm_we    = 1'b1;
				cm_waddr = clr_q;
			end
			ST_INIT: begin
				cm_we           = 1'b1;
				cm_waddr        = start_idx;
				cm_wdata.seen   = 1'b1;
				cm_wdata.parent = start_idx;
				ol_we           = 1'b1;
				ol_wdata        = start_idx;
			end
			ST_SEL_B:  cm_raddr = ol_q;
			ST_DEL_A:  ol_raddr = CELL_BITS'(del_j_q + 1'b1);
			ST_DEL_B: begin
				ol_we    = 1'b1;
				ol_waddr = del_j_q[CELL_BITS-1:0];
				ol_wdata = ol_q;
			end
			ST_CUR_RD: cm_raddr = cur_q;
			ST_CUR_WR: begin
				cm_we           = 1'b1;
				cm_wdata        = cm_q;
				cm_wdata.closed = 1'b1;
			end
			ST_NB:     cm_raddr = n_idx;
			ST_NB_CHK: h_start = !cm_q.closed;
			ST_NB_WR: begin
				cm_we    = 1'b1;
				cm_waddr = n_q;
				cm_wdata = '{closed: 1'b0, seen: 1'b1, parent: cur_q, steps: g_new,
					total: f_q};
				ol_we    = open_cnt_q < CNT_BITS'(CELLS);
				ol_waddr = open_cnt_q[CELL_BITS-1:0];
			end
			ST_DST_WR: begin
				cm_we           = 1'b1;
				cm_waddr        = dest_idx;
				cm_wdata.parent = cur_q;
			end
			ST_EM_CHK: begin
				out_load = out_free;
				if (em_trunc) begin
					out_sts = STS_TRUNC;
				end else begin
					out_x    = emit_c_q[SIDE_BITS-1:0];
					out_y    = emit_c_q[CELL_BITS-1:SIDE_BITS];
					out_sts  = STS_PATH;
					out_last = em_at_start;
				end
			end
			ST_STATUS: out_load = out_free;
			default:   ;
		endcase
	end

	// ---------------------------------------------------------------
	// Datapath registers, advanced per state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_cnt_q <= '0;
		end else begin
			case (state_q)
				ST_INIT:  open_cnt_q <= CNT_BITS'(1);
				ST_DEL_A: if (del_end) open_cnt_q <= open_cnt_q - 1'b1;
				ST_NB_WR: if (open_cnt_q < CNT_BITS'(CELLS)) open_cnt_q <= open_cnt_q + 1'b1;
				default:  ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				qin_q[0]  <= query.start_world_x;
				qin_q[1]  <= query.start_world_y;
				qin_q[2]  <= query.end_world_x;
				qin_q[3]  <= query.end_world_y;
				div_idx_q <= '0;
			end
			ST_DIV_WAIT: begin
				if (div_done) begin
					crd_q[div_idx_q] <= div_quot;
					div_idx_q        <= div_idx_q + 1'b1;
				end
			end
			ST_CHECK: begin
				clr_q <= '0;
				if (dest_out) stat_q <= STS_OUTSIDE;
				else if (same_cell) stat_q <= STS_SAME;
				else stat_q <= STS_NOPATH;
			end
			ST_CLEAR: clr_q <= clr_q + 1'b1;
			ST_INIT:  scan_i_q <= '0;
			ST_SEL_A: stat_q <= STS_NOPATH;
			ST_SEL_B: scan_cell_q <= ol_q;
			ST_SEL_C: begin
				if (sel_take) begin
					best_i_q    <= scan_i_q;
					best_cost_q <= cm_q.total;
					best_cell_q <= scan_cell_q;
				end
				if (sel_last) begin
					del_j_q   <= sel_take ? scan_i_q : best_i_q;
					cur_q     <= sel_take ? scan_cell_q : best_cell_q;
					del_ret_q <= 1'b0;
				end else begin
					scan_i_q <= scan_i_q + 1'b1;
				end
			end
			ST_DEL_B: del_j_q <= del_j_q + 1'b1;
			ST_CUR_WR: begin
				cur_g_q <= cm_q.steps;
				nb_ox_q <= '0;
				nb_oy_q <= '0;
			end
			ST_NB: begin
				n_q  <= n_idx;
				dx_q <= REL_BITS'(nx - $signed({2'b00, crd_q[2][SIDE_BITS-1:0]}));
				dy_q <= REL_BITS'(ny - $signed({2'b00, crd_q[3][SIDE_BITS-1:0]}));
			end
			ST_NB_CHK: nb_word_q <= cm_q;
			ST_H_WAIT: begin
				if (h_done) begin
					f_q      <= f_new;
					scan_i_q <= '0;
				end
			end
			ST_FIND_B: begin
				if (ol_q == n_q) begin
					del_j_q   <= scan_i_q;
					del_ret_q <= 1'b1;
				end else begin
					scan_i_q <= scan_i_q + 1'b1;
				end
			end
			ST_NB_NEXT: begin
				if (nb_oy_q == 2'd2) begin
					nb_oy_q <= '0;
					nb_ox_q <= nb_ox_q + 1'b1;
				end else begin
					nb_oy_q <= nb_oy_q + 1'b1;
				end
				scan_i_q <= '0;
			end
			ST_DST_WR: begin
				emit_c_q <= dest_idx;
				emit_k_q <= '0;
			end
			ST_EM_CHK: begin
				if (out_free && !em_trunc && !em_at_start) begin
					emit_c_q <= cm_q.parent;
					emit_k_q <= emit_k_q + 1'b1;
				end
			end
			default: ;
		endcase
	end

	// ---------------------------------------------------------------
	// Cell table and open list, one write and one registered read each
	always_ff @(posedge clk) begin
		if (cm_we) cm_mem[cm_waddr] <= cm_wdata;
		cm_q <= cm_mem[cm_raddr];
	end

	always_ff @(posedge clk) begin
		if (ol_we) ol_mem[ol_waddr] <= ol_wdata;
		ol_q <= ol_mem[ol_raddr];
	end

	// ---------------------------------------------------------------
	// Result register: hold the beat until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ov_q <= 1'b0;
		else if (out_load) ov_q <= 1'b1;
		else if (path.ready) ov_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			ox_q      <= out_x;
			oy_q      <= out_y;
			osts_q    <= out_sts;
			ol_last_q <= out_last;
		end
	end

	assign path.valid  = ov_q;
	assign path.cell_x = ox_q;
	assign path.cell_y = oy_q;
	assign path.status = osts_q;
	assign path.last   = ol_last_q;

	// ---------------------------------------------------------------
	// Checks
	a_open_bound: assert property (@(posedge clk) disable iff (!arst_n)
		open_cnt_q <= CNT_BITS'(CELLS))
		else $error("open list count beyond table size");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!ov_q || path.ready))
		else $error("result register overwritten while pending");

	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && osts_q != STS_PATH) |-> (ol_last_q && ox_q == '0 && oy_q == '0))
		else $error("status beat not final or carries a cell");

	a_query_start: assert property (@(posedge clk) disable iff (!arst_n)
		(query.valid && query.ready) |=> (state_q == ST_DIV_GO))
		else $error("accepted query did not start the divider");

endmodule
